// ===== rtl/core/i2cmts_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer: shared types and constants
// Item and result layouts, operation and bus command codes, store write beat.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  localparam int unsigned POS_W   = 5;
  localparam int unsigned LIMIT_W = 4;

  localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST = 4'd3;

  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_START_WR  = 2'd1,
    OP_START_WRD = 2'd2,
    OP_EVENT     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_SEND    = 3'd4,
    CMD_RECV    = 3'd5,
    CMD_ACK     = 3'd6,
    CMD_NAK     = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] slave_address;
    logic [4:0] write_length;
    logic [4:0] read_length;
    logic [3:0] buffer_index;
    logic [7:0] load_byte;
    logic       ack_received;
    logic [7:0] bus_byte;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] bus_command;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [3:0] rx_index;
    logic [7:0] rx_byte;
    logic       idle;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [3:0] slot;
    logic [7:0] data;
  } store_wr_t;

endpackage

// ===== rtl/core/i2cmts_if.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer: channel interfaces
// Valid/ready channels for items, results and the fail limit register.
// ----------------------------------------------------------------------------
interface i2cmts_in_if;
  logic                valid;
  logic                ready;
  i2cmts_pkg::item_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cmts_out_if;
  logic                valid;
  logic                ready;
  i2cmts_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cmts_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [i2cmts_pkg::LIMIT_W-1:0]     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/i2cmts_store.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer: write store
// Byte store filled by load beats and read at the write position, which wraps
// modulo the store depth.
// ----------------------------------------------------------------------------
module i2cmts_store #(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  logic                               clk_i,
  input  i2cmts_pkg::store_wr_t              wr_i,
  input  logic [i2cmts_pkg::POS_W-1:0]       rd_pos_i,
  output logic [7:0]                         rd_data_o
);

  // Load slots are four bits wide, so no more than sixteen entries are ever
  // written.
  localparam int unsigned Entries  = (STORE_DEPTH < 16) ? STORE_DEPTH : 16;
  localparam int unsigned IdxW     = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned PosCount = 2 ** i2cmts_pkg::POS_W;

  logic [7:0] store_q [Entries];
  logic [7:0] mod_tbl [PosCount];
  logic [7:0] rd_slot;

  for (genvar p = 0; p < PosCount; p++) begin : g_mod
    assign mod_tbl[p] = 8'(p % STORE_DEPTH);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && ({4'd0, wr_i.slot} < 8'(Entries))) begin
      store_q[wr_i.slot[IdxW-1:0]] <= wr_i.data;
    end
  end

  assign rd_slot   = mod_tbl[rd_pos_i];
  assign rd_data_o = (rd_slot < 8'(Entries)) ? store_q[rd_slot[IdxW-1:0]] : 8'd0;

endmodule

// ===== rtl/core/i2cmts_fsm.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer: transaction state machine
// Holds the transaction state and turns one item into one bus command.
// ----------------------------------------------------------------------------
module i2cmts_fsm (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  i2cmts_pkg::item_t                  item_i,
  input  logic [i2cmts_pkg::LIMIT_W-1:0]     fail_limit_i,
  input  logic [7:0]                         rd_data_i,
  output logic [i2cmts_pkg::POS_W-1:0]       rd_pos_o,
  output i2cmts_pkg::store_wr_t              wr_o,
  output i2cmts_pkg::result_t                result_o
);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_W_ADDR  = 4'd1,
    PH_W_FIRST = 4'd2,
    PH_W_DATA  = 4'd3,
    PH_W_DONE  = 4'd4,
    PH_R_ADDR  = 4'd5,
    PH_R_CHECK = 4'd6,
    PH_R_RECV  = 4'd7,
    PH_R_ACKED = 4'd8,
    PH_R_NAKED = 4'd9,
    PH_R_DONE  = 4'd10
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [6:0] addr_q, addr_d;
  logic [4:0] writes_q, writes_d;
  logic [4:0] reads_q, reads_d;
  logic [4:0] pos_q, pos_d;
  logic [3:0] naks_q, naks_d;

  logic [3:0]          limit;
  i2cmts_pkg::result_t res;

  assign limit = (fail_limit_i == 4'd0) ? 4'd1 : fail_limit_i;

  assign wr_o.en   = step_i && (item_i.operation == i2cmts_pkg::OP_LOAD);
  assign wr_o.slot = item_i.buffer_index;
  assign wr_o.data = item_i.load_byte;

  // The store is read at the position this item leaves behind.
  assign rd_pos_o = pos_d;

  always_comb begin
    phase_d  = phase_q;
    addr_d   = addr_q;
    writes_d = writes_q;
    reads_d  = reads_q;
    pos_d    = pos_q;
    naks_d   = naks_q;
    res      = '0;
    res.bus_command = i2cmts_pkg::CMD_NONE;

    unique case (item_i.operation)
      i2cmts_pkg::OP_LOAD: begin
      end
      i2cmts_pkg::OP_START_WR, i2cmts_pkg::OP_START_WRD: begin
        if (phase_q == PH_IDLE) begin
          res.accepted    = 1'b1;
          res.bus_command = i2cmts_pkg::CMD_START;
          addr_d   = item_i.slave_address;
          writes_d = item_i.write_length;
          reads_d  = (item_i.operation == i2cmts_pkg::OP_START_WRD) ?
                     item_i.read_length : 5'd0;
          pos_d    = '0;
          naks_d   = '0;
          if ((item_i.operation == i2cmts_pkg::OP_START_WRD) &&
              (item_i.write_length == 5'd0)) begin
            phase_d = PH_R_ADDR;
          end else begin
            phase_d = PH_W_ADDR;
          end
        end
      end
      default: begin
        unique case (phase_q)
          PH_W_ADDR: begin
            res.bus_command = i2cmts_pkg::CMD_SEND;
            res.tx_byte     = {addr_q, 1'b0};
            phase_d         = PH_W_FIRST;
          end
          PH_W_FIRST: begin
            if (!item_i.ack_received) begin
              res.bus_command = i2cmts_pkg::CMD_STOP;
              phase_d         = PH_W_DONE;
            end else if (writes_q != 5'd0) begin
              res.bus_command = i2cmts_pkg::CMD_SEND;
              res.tx_byte     = rd_data_i;
              phase_d         = PH_W_DATA;
            end else if (reads_q != 5'd0) begin
              pos_d           = '0;
              res.bus_command = i2cmts_pkg::CMD_RESTART;
              phase_d         = PH_R_ADDR;
            end else begin
              res.bus_command = i2cmts_pkg::CMD_STOP;
              phase_d         = PH_W_DONE;
            end
          end
          PH_W_DATA: begin
            if (item_i.ack_received) begin
              writes_d = writes_q - 5'd1;
              pos_d    = pos_q + 5'd1;
              naks_d   = '0;
            end else begin
              naks_d   = naks_q + 4'd1;
            end
            if (naks_d >= limit) begin
              res.bus_command = i2cmts_pkg::CMD_STOP;
              phase_d         = PH_W_DONE;
            end else if (writes_d != 5'd0) begin
              res.bus_command = i2cmts_pkg::CMD_SEND;
              res.tx_byte     = rd_data_i;
            end else if (reads_q != 5'd0) begin
              pos_d           = '0;
              res.bus_command = i2cmts_pkg::CMD_RESTART;
              phase_d         = PH_R_ADDR;
            end else begin
              res.bus_command = i2cmts_pkg::CMD_STOP;
              phase_d         = PH_W_DONE;
            end
          end
          PH_R_ADDR: begin
            res.bus_command = i2cmts_pkg::CMD_SEND;
            res.tx_byte     = {addr_q, 1'b1};
            phase_d         = PH_R_CHECK;
          end
          PH_R_CHECK: begin
            if (item_i.ack_received && (reads_q != 5'd0)) begin
              res.bus_command = i2cmts_pkg::CMD_RECV;
              phase_d         = PH_R_RECV;
            end else begin
              res.bus_command = i2cmts_pkg::CMD_STOP;
              phase_d         = PH_R_DONE;
            end
          end
          PH_R_RECV: begin
            res.rx_valid = 1'b1;
            res.rx_index = pos_q[3:0];
            res.rx_byte  = item_i.bus_byte;
            pos_d        = pos_q + 5'd1;
            if (reads_q != 5'd0) begin
              reads_d = reads_q - 5'd1;
            end
            // The last byte is taken and then refused with a nak.
            if (reads_d != 5'd0) begin
              res.bus_command = i2cmts_pkg::CMD_ACK;
              phase_d         = PH_R_ACKED;
            end else begin
              res.bus_command = i2cmts_pkg::CMD_NAK;
              phase_d         = PH_R_NAKED;
            end
          end
          PH_R_ACKED: begin
            res.bus_command = i2cmts_pkg::CMD_RECV;
            phase_d         = PH_R_RECV;
          end
          PH_R_NAKED: begin
            res.bus_command = i2cmts_pkg::CMD_STOP;
            phase_d         = PH_R_DONE;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    endcase

    res.idle = (phase_d == PH_IDLE);
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      addr_q   <= '0;
      writes_q <= '0;
      reads_q  <= '0;
      pos_q    <= '0;
      naks_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      addr_q   <= addr_d;
      writes_q <= writes_d;
      reads_q  <= reads_d;
      pos_q    <= pos_d;
      naks_q   <= naks_d;
    end
  end

endmodule

// ===== rtl/core/i2c_master_transfer_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Runs write and write-then-read transactions over a byte-level bus engine,
// answering every item with one result beat.
//
//   channel  direction  payload                     notes
//   cfg_i    in         fail_limit (4 bits)         always ready
//   in_i     in         item_t                      load, start or bus event
//   out_o    out        result_t                    one beat per item
//
// One item per cycle is sustained while out_o is not stalled; each item is held
// in the input register and its result in the output register, which drives out_o.
// Reset empties both registers and returns the transaction state to idle with
// a fail limit of three; the write store keeps no reset value.
// A stalled result holds the next item in the input register, so in_i stops
// accepting only when both registers are full.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_unit #(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  i2cmts_cfg_if.sink           cfg_i,
  i2cmts_in_if.sink            in_i,
  i2cmts_out_if.source         out_o
);

  logic                              in_valid_q;
  i2cmts_pkg::item_t                 in_item_q;
  logic                              out_valid_q;
  i2cmts_pkg::result_t               out_res_q;
  logic [i2cmts_pkg::LIMIT_W-1:0]    fail_limit_q;

  logic                              advance;
  logic                              in_take;
  logic [i2cmts_pkg::POS_W-1:0]      rd_pos;
  logic [7:0]                        rd_data;
  i2cmts_pkg::store_wr_t             store_wr;
  i2cmts_pkg::result_t               result;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign in_take     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_res_q;

  i2cmts_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_i      (store_wr),
    .rd_pos_i  (rd_pos),
    .rd_data_o (rd_data)
  );

  i2cmts_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (in_item_q),
    .fail_limit_i (fail_limit_q),
    .rd_data_i    (rd_data),
    .rd_pos_o     (rd_pos),
    .wr_o         (store_wr),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      fail_limit_q <= i2cmts_pkg::FAIL_LIMIT_RST;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        fail_limit_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_i.data;
    end
    if (advance) begin
      out_res_q <= result;
    end
  end

endmodule
